[sv/rpnp_pkg.sv]
// Package with character codes, radix encoding and defaults for the literal parser.
`timescale 1ns / 1ps
`default_nettype none

package rpnp_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int COUNT_BITS_DEFAULT = 8;

   localparam int CHAR_BITS   = 8;
   localparam int NUMBER_BITS = 32;
   localparam int USED_BITS   = 8;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_ONE    = 8'h31;
   localparam logic [CHAR_BITS-1:0] CH_SEVEN  = 8'h37;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_LX     = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_UX     = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_LB     = 8'h62;
   localparam logic [CHAR_BITS-1:0] CH_UB     = 8'h42;
   localparam logic [CHAR_BITS-1:0] CH_LA     = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h66;
   localparam logic [CHAR_BITS-1:0] CH_UA     = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UF     = 8'h46;

   // Radix in effect for the literal being parsed.
   typedef enum logic [4:0] {
      RADIX_NONE = 5'b00001,
      RADIX_BIN  = 5'b00010,
      RADIX_OCT  = 5'b00100,
      RADIX_DEC  = 5'b01000,
      RADIX_HEX  = 5'b10000
   } radix_type;

endpackage

`default_nettype wire

[sv/radix_prefixed_number_parser_unit.sv]
// Top level of the radix-prefixed integer literal parser.
// Data path: a character accepted into the input register is parsed from there; a terminating
// character then loads the result register, which drives rsp_tvalid.
// Throughput: one character per cycle; the input register holds a terminator only
// while the result register is still occupied and not taken.
// Reset: synchronous, active high; clears the handshake state and the parse state.
`timescale 1ns / 1ps
`default_nettype none

module radix_prefixed_number_parser_unit #(
   parameter int VALUE_BITS = rpnp_pkg::VALUE_BITS_DEFAULT,
   parameter int COUNT_BITS = rpnp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rpnp_pkg::CHAR_BITS-1:0]    req_tdata,   // [7:0] char_code
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rpnp_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,   // [31:0] number, [39:32] chars_used
   output logic                                   rsp_tuser    // [0] is_valid
);

   // Input register.
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [rpnp_pkg::CHAR_BITS-1:0]    char_ff;

   // Parse state.
   rpnp_pkg::radix_type               radix_ff;
   rpnp_pkg::radix_type               radix_in;
   logic                              minus_ff;
   logic                              minus_in;
   logic [VALUE_BITS-1:0]             acc_ff;
   logic [VALUE_BITS-1:0]             acc_in;
   logic [COUNT_BITS-1:0]             count_ff;
   logic [COUNT_BITS-1:0]             count_in;

   // Result register.
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic                              is_valid_ff;
   logic [rpnp_pkg::NUMBER_BITS-1:0]  number_ff;
   logic [rpnp_pkg::USED_BITS-1:0]    used_ff;

   logic                              out_free;
   logic                              stage_go;
   logic                              finish;
   logic                              digit_ok;
   logic [3:0]                        digit;
   logic                              in_range;
   logic [VALUE_BITS-1:0]             acc_scaled;
   logic signed [VALUE_BITS-1:0]      signed_value;
   logic                              radix_set;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Digit decode of the held character, all cases in parallel.
   always_comb begin
      digit_ok = 1'b1;
      digit    = '0;
      if (char_ff >= rpnp_pkg::CH_LA && char_ff <= rpnp_pkg::CH_LF) begin
         digit = 4'(char_ff - rpnp_pkg::CH_LA + 8'd10);
      end else if (char_ff >= rpnp_pkg::CH_UA && char_ff <= rpnp_pkg::CH_UF) begin
         digit = 4'(char_ff - rpnp_pkg::CH_UA + 8'd10);
      end else if (char_ff >= rpnp_pkg::CH_ZERO && char_ff <= rpnp_pkg::CH_NINE) begin
         digit = 4'(char_ff - rpnp_pkg::CH_ZERO);
      end else begin
         digit_ok = 1'b0;
      end
   end

   // Range check and scaling by the radix; the scale is only shifts and one add.
   always_comb begin
      in_range   = 1'b0;
      acc_scaled = '0;
      case (radix_ff)
         rpnp_pkg::RADIX_BIN: begin
            in_range   = (digit <= 4'd1);
            acc_scaled = acc_ff << 1;
         end
         rpnp_pkg::RADIX_OCT: begin
            in_range   = (digit <= 4'd7);
            acc_scaled = acc_ff << 3;
         end
         rpnp_pkg::RADIX_DEC: begin
            in_range   = (digit <= 4'd9);
            acc_scaled = (acc_ff << 3) + (acc_ff << 1);
         end
         rpnp_pkg::RADIX_HEX: begin
            in_range   = 1'b1;
            acc_scaled = acc_ff << 4;
         end
         default: begin
            in_range   = 1'b0;
            acc_scaled = '0;
         end
      endcase
   end

   assign radix_set = (radix_ff == rpnp_pkg::RADIX_BIN) || (radix_ff == rpnp_pkg::RADIX_OCT) ||
                      (radix_ff == rpnp_pkg::RADIX_DEC) || (radix_ff == rpnp_pkg::RADIX_HEX);

   // Next parse state for the held character.
   always_comb begin
      finish   = 1'b0;
      radix_in = radix_ff;
      minus_in = minus_ff;
      acc_in   = acc_ff;
      if (!radix_set) begin
         if (char_ff == rpnp_pkg::CH_MINUS) begin
            if (minus_ff) begin
               finish = 1'b1;
            end else begin
               minus_in = 1'b1;
            end
         end else if (char_ff == rpnp_pkg::CH_DOLLAR) begin
            radix_in = rpnp_pkg::RADIX_HEX;
         end else if (char_ff == rpnp_pkg::CH_ZERO) begin
            radix_in = rpnp_pkg::RADIX_OCT;
            acc_in   = '0;
         end else if (char_ff >= rpnp_pkg::CH_ONE && char_ff <= rpnp_pkg::CH_NINE) begin
            radix_in = rpnp_pkg::RADIX_DEC;
            acc_in   = VALUE_BITS'(digit);
         end else begin
            finish = 1'b1;
         end
      end else if (radix_ff == rpnp_pkg::RADIX_OCT && acc_ff == '0) begin
         // Still inside the leading zero, so a prefix letter can switch the radix.
         if (char_ff == rpnp_pkg::CH_LX || char_ff == rpnp_pkg::CH_UX) begin
            radix_in = rpnp_pkg::RADIX_HEX;
         end else if (char_ff == rpnp_pkg::CH_LB || char_ff == rpnp_pkg::CH_UB) begin
            radix_in = rpnp_pkg::RADIX_BIN;
         end else if (char_ff >= rpnp_pkg::CH_ZERO && char_ff <= rpnp_pkg::CH_SEVEN) begin
            acc_in = VALUE_BITS'(digit);
         end else begin
            finish = 1'b1;
         end
      end else begin
         if (digit_ok && in_range) begin
            acc_in = acc_scaled + VALUE_BITS'(digit);
         end else begin
            finish = 1'b1;
         end
      end

      if (finish) begin
         radix_in = rpnp_pkg::RADIX_NONE;
         minus_in = 1'b0;
         acc_in   = '0;
         count_in = '0;
      end else if (count_ff != COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   assign signed_value = minus_ff ? $signed(-acc_ff) : $signed(acc_ff);

   // A terminator needs the result register; other characters only update the state.
   assign out_free     = !out_valid_ff || rsp_tready;
   assign stage_go     = in_valid_ff && (!finish || out_free);
   assign req_tready   = !in_valid_ff || stage_go;
   assign in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !stage_go);
   assign out_valid_in = (stage_go && finish) ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         radix_ff     <= rpnp_pkg::RADIX_NONE;
         minus_ff     <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
         if (stage_go) begin
            radix_ff <= radix_in;
            minus_ff <= minus_in;
            acc_ff   <= acc_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
      end
      if (stage_go && finish) begin
         is_valid_ff <= radix_set;
         number_ff   <= radix_set ? rpnp_pkg::NUMBER_BITS'(signed_value) : '0;
         used_ff     <= rpnp_pkg::USED_BITS'(count_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = is_valid_ff;
   assign rsp_tdata  = {used_ff, number_ff};

`ifndef SYNTHESIS
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      stage_go && finish |=> out_valid_ff)
      else $error("terminator did not load the result register");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      stage_go && finish |=> radix_ff == rpnp_pkg::RADIX_NONE && count_ff == '0 && !minus_ff)
      else $error("parse state not cleared after a result");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      stage_go && !finish |=> count_ff >= $past(count_ff))
      else $error("character count went down without a result");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[rpnp_pkg::NUMBER_BITS-1:0] == '0)
      else $error("result without a radix carries a nonzero number");
`endif

endmodule

`default_nettype wire

[tb/tb_radix_prefixed_number_parser_unit.sv]
// Self-checking testbench for the radix-prefixed integer literal parser.
`timescale 1ns / 1ps

module tb_radix_prefixed_number_parser_unit;

   localparam int CHAR_TOTAL  = 1450;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;

   localparam logic [rpnp_pkg::CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [rpnp_pkg::CHAR_BITS-1:0] CH_LG    = 8'h67;
   localparam logic [rpnp_pkg::CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [rpnp_pkg::CHAR_BITS-1:0] CH_ALL1  = 8'hFF;

   localparam int DIRECTED_COUNT = 24;
   localparam logic [rpnp_pkg::CHAR_BITS-1:0] DIRECTED_CHARS [DIRECTED_COUNT] = '{
      rpnp_pkg::CH_MINUS, rpnp_pkg::CH_MINUS,
      CH_NUL, CH_ALL1,
      rpnp_pkg::CH_MINUS, rpnp_pkg::CH_DOLLAR, rpnp_pkg::CH_UA, CH_LG,
      rpnp_pkg::CH_ZERO, rpnp_pkg::CH_UB, rpnp_pkg::CH_ONE, rpnp_pkg::CH_ZERO + 8'd2,
      rpnp_pkg::CH_ZERO, rpnp_pkg::CH_SEVEN, rpnp_pkg::CH_LX,
      rpnp_pkg::CH_ZERO, rpnp_pkg::CH_UX, rpnp_pkg::CH_NINE, CH_SPACE,
      rpnp_pkg::CH_MINUS, rpnp_pkg::CH_NINE, rpnp_pkg::CH_LA,
      rpnp_pkg::CH_DOLLAR, CH_SPACE
   };

   // Tracks the literal being parsed and queues the result each terminator produces.
   class literal_tracker;
      typedef struct {
         bit                             valid;
         bit [rpnp_pkg::NUMBER_BITS-1:0] number;
         bit [rpnp_pkg::USED_BITS-1:0]   used;
      } literal_type;

      rpnp_pkg::radix_type            radix;
      bit                             minus;
      bit [rpnp_pkg::NUMBER_BITS-1:0] acc;
      bit [rpnp_pkg::USED_BITS-1:0]   used;
      literal_type                    expected_literals[$];
      int                             errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         radix = rpnp_pkg::RADIX_NONE;
         minus = 1'b0;
         acc   = '0;
         used  = '0;
      endfunction

      function int pending();
         return expected_literals.size();
      endfunction

      function void close_literal();
         literal_type lit;
         lit.valid  = (radix != rpnp_pkg::RADIX_NONE);
         lit.number = lit.valid ? (minus ? -acc : acc) : '0;
         lit.used   = used;
         expected_literals.push_back(lit);
         clear();
      endfunction

      function void note_char(bit [rpnp_pkg::CHAR_BITS-1:0] c);
         bit [31:0] d;
         bit [31:0] base;
         if (radix == rpnp_pkg::RADIX_NONE) begin
            if (c == rpnp_pkg::CH_MINUS) begin
               // A second sign before any radix ends the literal.
               if (minus) begin
                  close_literal();
                  return;
               end
               minus = 1'b1;
            end else if (c == rpnp_pkg::CH_DOLLAR) begin
               radix = rpnp_pkg::RADIX_HEX;
            end else if (c == rpnp_pkg::CH_ZERO) begin
               radix = rpnp_pkg::RADIX_OCT;
               acc   = '0;
            end else if (c >= rpnp_pkg::CH_ONE && c <= rpnp_pkg::CH_NINE) begin
               radix = rpnp_pkg::RADIX_DEC;
               acc   = rpnp_pkg::NUMBER_BITS'(c - rpnp_pkg::CH_ZERO);
            end else begin
               close_literal();
               return;
            end
         end else if (radix == rpnp_pkg::RADIX_OCT && acc == '0) begin
            // A zero-valued octal literal may still turn into hex or binary.
            if (c == rpnp_pkg::CH_LX || c == rpnp_pkg::CH_UX) begin
               radix = rpnp_pkg::RADIX_HEX;
            end else if (c == rpnp_pkg::CH_LB || c == rpnp_pkg::CH_UB) begin
               radix = rpnp_pkg::RADIX_BIN;
            end else if (c >= rpnp_pkg::CH_ZERO && c <= rpnp_pkg::CH_SEVEN) begin
               acc = rpnp_pkg::NUMBER_BITS'(c - rpnp_pkg::CH_ZERO);
            end else begin
               close_literal();
               return;
            end
         end else begin
            if (c >= rpnp_pkg::CH_LA && c <= rpnp_pkg::CH_LF) begin
               d = 32'(c - rpnp_pkg::CH_LA) + 32'd10;
            end else if (c >= rpnp_pkg::CH_UA && c <= rpnp_pkg::CH_UF) begin
               d = 32'(c - rpnp_pkg::CH_UA) + 32'd10;
            end else if (c >= rpnp_pkg::CH_ZERO && c <= rpnp_pkg::CH_NINE) begin
               d = 32'(c - rpnp_pkg::CH_ZERO);
            end else begin
               close_literal();
               return;
            end
            case (radix)
               rpnp_pkg::RADIX_BIN: base = 2;
               rpnp_pkg::RADIX_OCT: base = 8;
               rpnp_pkg::RADIX_DEC: base = 10;
               default:             base = 16;
            endcase
            if (d >= base) begin
               close_literal();
               return;
            end
            acc = acc * base + d;
         end
         if (used != '1) used++;
      endfunction

      function void flag_error(string msg);
         errors++;
         if (errors <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void check_result(bit [rpnp_pkg::RSP_DATA_BITS-1:0] data, bit user);
         literal_type want;
         if (expected_literals.size() == 0) begin
            flag_error($sformatf("unexpected result: valid=%0d number=%h used=%0d",
                                 user, data[31:0], data[39:32]));
            return;
         end
         want = expected_literals.pop_front();
         if (user != want.valid || data[31:0] != want.number || data[39:32] != want.used)
            flag_error($sformatf({"result mismatch: expected valid=%0d number=%h used=%0d,",
                                  " got valid=%0d number=%h used=%0d"},
                                 want.valid, want.number, want.used,
                                 user, data[31:0], data[39:32]));
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [rpnp_pkg::CHAR_BITS-1:0]     req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [rpnp_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;

   literal_tracker board = new();
   int sent_count  = 0;
   int idle_pct    = 19;
   int stall_pct   = 88;
   int cycle_count = 0;
   int literal_count = 0;

   radix_prefixed_number_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: check every accepted beat, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_char(input logic [rpnp_pkg::CHAR_BITS-1:0] c);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      board.note_char(c);
      sent_count++;
      if (sent_count < CHAR_TOTAL / 3) begin
         idle_pct  = 19;
         stall_pct = 88;
      end else if (sent_count < 2 * CHAR_TOTAL / 3) begin
         idle_pct  = 88;
         stall_pct = 19;
      end else begin
         idle_pct  = 0;
         stall_pct = 0;
      end
   endtask

   // Mostly well-formed literals with random digits; the rest is raw noise.
   task automatic send_literal();
      int kind;
      int ndig;
      int base;
      int d;
      logic [rpnp_pkg::CHAR_BITS-1:0] ch;
      literal_count++;
      if ($urandom_range(99) < 12) begin
         send_char(rpnp_pkg::CHAR_BITS'($urandom_range(255)));
         return;
      end
      if ($urandom_range(3) == 0) send_char(rpnp_pkg::CH_MINUS);
      if ($urandom_range(19) == 0) send_char(rpnp_pkg::CH_MINUS);
      kind = $urandom_range(19);
      if (kind <= 3) begin
         send_char(rpnp_pkg::CH_DOLLAR);
         base = 16;
      end else if (kind <= 7) begin
         send_char(rpnp_pkg::CH_ZERO);
         send_char($urandom_range(1) ? rpnp_pkg::CH_LX : rpnp_pkg::CH_UX);
         base = 16;
      end else if (kind <= 10) begin
         send_char(rpnp_pkg::CH_ZERO);
         send_char($urandom_range(1) ? rpnp_pkg::CH_LB : rpnp_pkg::CH_UB);
         base = 2;
      end else if (kind <= 13) begin
         send_char(rpnp_pkg::CH_ZERO);
         base = 8;
      end else if (kind <= 18) begin
         send_char(rpnp_pkg::CHAR_BITS'(rpnp_pkg::CH_ONE + $urandom_range(8)));
         base = 10;
      end else begin
         // 1 followed by eleven octal zeros wraps to zero, so the hex prefix still applies.
         send_char(rpnp_pkg::CH_ZERO);
         send_char(rpnp_pkg::CH_ONE);
         repeat (11) send_char(rpnp_pkg::CH_ZERO);
         send_char($urandom_range(1) ? rpnp_pkg::CH_LX : rpnp_pkg::CH_UX);
         base = 16;
      end
      if (literal_count == 40 || $urandom_range(399) == 0)
         ndig = 260 + $urandom_range(40);
      else
         ndig = $urandom_range(12);
      repeat (ndig) begin
         d = $urandom_range(base - 1);
         if (d < 10) ch = rpnp_pkg::CHAR_BITS'(rpnp_pkg::CH_ZERO + d);
         else ch = rpnp_pkg::CHAR_BITS'(($urandom_range(1) ? rpnp_pkg::CH_LA : rpnp_pkg::CH_UA)
                                        + d - 10);
         send_char(ch);
      end
      case ($urandom_range(3))
         0: send_char(CH_SPACE);
         1: begin
            case (base)
               2:  send_char(rpnp_pkg::CHAR_BITS'(rpnp_pkg::CH_ZERO + 2 + $urandom_range(7)));
               8:  send_char(rpnp_pkg::CHAR_BITS'(rpnp_pkg::CH_NINE - $urandom_range(1)));
               10: send_char(rpnp_pkg::CHAR_BITS'(rpnp_pkg::CH_LA + $urandom_range(5)));
               default: send_char(CH_LG);
            endcase
         end
         default: send_char(rpnp_pkg::CHAR_BITS'($urandom_range(255)));
      endcase
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) send_char(DIRECTED_CHARS[i]);
      while (sent_count < CHAR_TOTAL) send_literal();
      // A closing terminator so the last literal also reports.
      send_char(CH_NUL);
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
